// ----- design/mip_chain_layout_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the mip chain layout core
// Shared property templates clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIP_CHAIN_LAYOUT_CORE_ASSERT_SVH
`define MIP_CHAIN_LAYOUT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold at every clock edge outside reset.
`define MCL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// ----- design/mcl_pkg.sv -----
// ----------------------------------------------------------------------------
// Mip chain layout package
// Shared widths, format codes, descriptor and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcl_pkg;

    localparam int MCL_MAX_LEVELS  = 16;
    localparam int MCL_QUEUE_DEPTH = 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 144;

    localparam logic [2:0] FMT_BLK8  = 3'd0;
    localparam logic [2:0] FMT_BLK16 = 3'd1;
    localparam logic [2:0] FMT_PIX4  = 3'd2;
    localparam logic [2:0] FMT_PIX1  = 3'd3;

    localparam logic [30:0] SIZE_MAX  = 31'h7FFF_FFFF;
    localparam logic [16:0] PITCH_MAX = 17'h1_FFFF;

    typedef enum logic [2:0] {
        CLS_BLK8,
        CLS_BLK16,
        CLS_PIX4,
        CLS_PIX1,
        CLS_NONE
    } cls_t;

    typedef struct packed {
        logic [14:0] w;
        logic [14:0] h;
        logic [11:0] d;
        cls_t        cls;
        logic [3:0]  last_idx;
    } desc_t;

    typedef struct packed {
        logic [3:0]  level_index;
        logic [30:0] byte_offset;
        logic [30:0] byte_size;
        logic [16:0] row_pitch;
        logic [14:0] row_count;
        logic [14:0] level_width;
        logic [14:0] level_height;
        logic [11:0] level_depth;
        logic        last_level;
    } res_t;

endpackage

`default_nettype wire

// ----- design/mip_chain_layout_core.sv -----
// ----------------------------------------------------------------------------
// Mip chain layout core
// Lays out the mip chain of one texture: one result per level with offset,
// size, pitch, row count and level dimensions.
// ----------------------------------------------------------------------------
// Path: front end register, descriptor queue, level sequencer, product stage
// register and output register. Throughput: one level result per cycle while
// the output does not stall; the sequencer loads the next request in the
// cycle it issues the last level of the current one.
// Reset: rst_n clears all valid flags, queue pointers and the busy flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mip_chain_layout_core_assert.svh"

module mip_chain_layout_core #(
    parameter int MAX_LEVELS  = mcl_pkg::MCL_MAX_LEVELS,
    parameter int QUEUE_DEPTH = mcl_pkg::MCL_QUEUE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // base_width, base_height, base_depth, format_class, level_count
    input  wire logic [mcl_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // level_index, byte_offset, byte_size, row_pitch, row_count,
    // level_width, level_height, level_depth
    output logic [mcl_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);
    import mcl_pkg::*;

    logic  fq_valid;
    logic  fq_ready;
    desc_t fq_desc;
    logic  qb_valid;
    logic  qb_ready;
    desc_t qb_desc;
    res_t  res;

    mcl_front #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_desc   (fq_desc)
    );

    mcl_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_desc   (fq_desc),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_desc  (qb_desc)
    );

    mcl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_desc    (qb_desc),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {4'b0000, res.level_depth, res.level_height, res.level_width,
                      res.row_count, res.row_pitch, res.byte_size, res.byte_offset,
                      res.level_index};
    assign m_tlast = res.last_level;

    `MCL_ASSERT_IMPL(a_first_offset_zero, m_tvalid && (res.level_index == '0),
        res.byte_offset == '0, "Level zero result has a nonzero offset.")
    `MCL_ASSERT_IMPL(a_depth_floor, m_tvalid && (res.level_index != '0),
        res.level_depth != '0, "Depth of a later level fell to zero.")
    `MCL_ASSERT_IMPL(a_unsupported_zero, m_tvalid && (res.byte_size == '0),
        (res.row_pitch == '0) && (res.row_count == '0),
        "Zero size result carries a pitch or row count.")
    `MCL_ASSERT_ALWAYS(a_dims_nonzero,
        !m_tvalid || ((res.level_width != '0) && (res.level_height != '0)),
        "Level width or height is zero.")

endmodule

`default_nettype wire

// ----- design/mcl_front.sv -----
// ----------------------------------------------------------------------------
// Mip chain layout front end
// Accepts texture requests, decodes the format and clamps the level count.
// ----------------------------------------------------------------------------
`default_nettype none

module mcl_front #(
    parameter int MAX_LEVELS = mcl_pkg::MCL_MAX_LEVELS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mcl_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                q_valid,
    input  wire logic                           q_ready,
    output mcl_pkg::desc_t                      q_desc
);
    import mcl_pkg::*;

    logic        f_valid_reg;
    desc_t       f_desc_reg;
    desc_t       desc_next;
    logic [14:0] in_w;
    logic [14:0] in_h;
    logic [2:0]  in_cls;
    logic [4:0]  in_count;
    logic [4:0]  count_sat;
    logic [4:0]  count_m1;
    logic        s_fire;

    assign in_w     = s_tdata[14:0];
    assign in_h     = s_tdata[29:15];
    assign in_cls   = s_tdata[44:42];
    assign in_count = s_tdata[49:45];

    assign s_tready = !f_valid_reg || q_ready;
    assign s_fire   = s_tvalid && s_tready;

    assign count_sat = (in_count > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : in_count;
    assign count_m1  = count_sat - 5'd1;

    always_comb
    begin
        desc_next.w        = (in_w == '0) ? 15'd1 : in_w;
        desc_next.h        = (in_h == '0) ? 15'd1 : in_h;
        desc_next.d        = s_tdata[41:30];
        desc_next.last_idx = count_m1[3:0];
        unique case (in_cls)
            FMT_BLK8:  desc_next.cls = CLS_BLK8;
            FMT_BLK16: desc_next.cls = CLS_BLK16;
            FMT_PIX4:  desc_next.cls = CLS_PIX4;
            FMT_PIX1:  desc_next.cls = CLS_PIX1;
            default:   desc_next.cls = CLS_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            f_valid_reg <= (in_count != '0);
        end
        else if (q_ready)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            f_desc_reg <= desc_next;
        end
    end

    assign q_valid = f_valid_reg;
    assign q_desc  = f_desc_reg;

endmodule

`default_nettype wire

// ----- design/mcl_queue.sv -----
// ----------------------------------------------------------------------------
// Mip chain layout descriptor queue
// Short FIFO that decouples the front end from the level sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mcl_queue #(
    parameter int QUEUE_DEPTH = mcl_pkg::MCL_QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mcl_pkg::desc_t  in_desc,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output mcl_pkg::desc_t       out_desc
);
    import mcl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_desc  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_desc;
        end
    end

endmodule

`default_nettype wire

// ----- design/mcl_back.sv -----
// ----------------------------------------------------------------------------
// Mip chain layout back end
// Steps through the levels of one texture, multiplies out the level size and
// accumulates the running byte offset into a registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module mcl_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire mcl_pkg::desc_t  q_desc,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output mcl_pkg::res_t        res
);
    import mcl_pkg::*;

    logic        busy_reg;
    logic [14:0] w_reg;
    logic [14:0] h_reg;
    logic [11:0] d_reg;
    cls_t        cls_reg;
    logic [3:0]  idx_reg;
    logic [3:0]  last_idx_reg;

    logic        p_valid_reg;
    logic [29:0] p_prod_reg;
    cls_t        p_cls_reg;
    logic [16:0] p_pitch_reg;
    logic [14:0] p_rows_reg;
    logic [14:0] p_w_reg;
    logic [14:0] p_h_reg;
    logic [11:0] p_d_reg;
    logic [3:0]  p_idx_reg;
    logic        p_last_reg;

    logic        o_valid_reg;
    res_t        o_res_reg;
    logic [30:0] run_reg;

    logic        o_ready;
    logic        p_ready;
    logic        gen_fire;
    logic        gen_last;
    logic        q_pop;
    logic        p_move;

    logic [15:0] w_p3;
    logic [15:0] h_p3;
    logic [13:0] bw;
    logic [13:0] bh;
    logic [14:0] op_a;
    logic [14:0] op_b;
    logic [17:0] pitch_wide;
    logic [16:0] pitch_sat;
    logic [14:0] rows;
    logic [29:0] prod;
    logic [14:0] w_half;
    logic [14:0] h_half;
    logic [11:0] d_half;

    logic [33:0] size_wide;
    logic [30:0] size_sat;
    logic [30:0] off_cur;
    logic [31:0] off_sum;
    logic [30:0] run_next;

    assign o_ready  = !o_valid_reg || res_ready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign p_move   = p_valid_reg && o_ready;
    assign gen_fire = busy_reg && p_ready;
    assign gen_last = (idx_reg == last_idx_reg);
    assign q_pop    = q_valid && (!busy_reg || (gen_fire && gen_last));
    assign q_ready  = !busy_reg || (gen_fire && gen_last);

    assign w_p3   = {1'b0, w_reg} + 16'd3;
    assign h_p3   = {1'b0, h_reg} + 16'd3;
    assign bw     = w_p3[15:2];
    assign bh     = h_p3[15:2];
    assign w_half = (w_reg[14:1] == '0) ? 15'd1 : {1'b0, w_reg[14:1]};
    assign h_half = (h_reg[14:1] == '0) ? 15'd1 : {1'b0, h_reg[14:1]};
    assign d_half = (d_reg[11:1] == '0) ? 12'd1 : {1'b0, d_reg[11:1]};

    always_comb
    begin
        case (cls_reg)
            CLS_BLK8:
            begin
                op_a       = {1'b0, bw};
                op_b       = {1'b0, bh};
                pitch_wide = {1'b0, bw, 3'b000};
                rows       = {1'b0, bh};
            end
            CLS_BLK16:
            begin
                op_a       = {1'b0, bw};
                op_b       = {1'b0, bh};
                pitch_wide = {bw, 4'b0000};
                rows       = {1'b0, bh};
            end
            CLS_PIX4:
            begin
                op_a       = w_reg;
                op_b       = h_reg;
                pitch_wide = {1'b0, w_reg, 2'b00};
                rows       = h_reg;
            end
            CLS_PIX1:
            begin
                op_a       = w_reg;
                op_b       = h_reg;
                pitch_wide = {3'b000, w_reg};
                rows       = h_reg;
            end
            default:
            begin
                op_a       = '0;
                op_b       = '0;
                pitch_wide = '0;
                rows       = '0;
            end
        endcase
    end

    assign pitch_sat = pitch_wide[17] ? PITCH_MAX : pitch_wide[16:0];
    assign prod      = op_a * op_b;

    always_comb
    begin
        case (p_cls_reg)
            CLS_BLK8:  size_wide = {1'b0, p_prod_reg, 3'b000};
            CLS_BLK16: size_wide = {p_prod_reg, 4'b0000};
            CLS_PIX4:  size_wide = {2'b00, p_prod_reg, 2'b00};
            CLS_PIX1:  size_wide = {4'b0000, p_prod_reg};
            default:   size_wide = '0;
        endcase
    end

    assign size_sat = (size_wide[33:31] != '0) ? SIZE_MAX : size_wide[30:0];
    assign off_cur  = (p_idx_reg == '0) ? '0 : run_reg;
    assign off_sum  = {1'b0, off_cur} + {1'b0, size_sat};
    assign run_next = off_sum[31] ? SIZE_MAX : off_sum[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (gen_fire && gen_last)
            begin
                busy_reg <= 1'b0;
            end
            if (p_ready)
            begin
                p_valid_reg <= gen_fire;
            end
            if (o_ready)
            begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            w_reg        <= q_desc.w;
            h_reg        <= q_desc.h;
            d_reg        <= q_desc.d;
            cls_reg      <= q_desc.cls;
            idx_reg      <= '0;
            last_idx_reg <= q_desc.last_idx;
        end
        else if (gen_fire)
        begin
            w_reg   <= w_half;
            h_reg   <= h_half;
            d_reg   <= d_half;
            idx_reg <= idx_reg + 1'b1;
        end

        if (gen_fire)
        begin
            p_prod_reg  <= prod;
            p_cls_reg   <= cls_reg;
            p_pitch_reg <= pitch_sat;
            p_rows_reg  <= rows;
            p_w_reg     <= w_reg;
            p_h_reg     <= h_reg;
            p_d_reg     <= d_reg;
            p_idx_reg   <= idx_reg;
            p_last_reg  <= gen_last;
        end

        if (p_move)
        begin
            run_reg                <= run_next;
            o_res_reg.level_index  <= p_idx_reg;
            o_res_reg.byte_offset  <= off_cur;
            o_res_reg.byte_size    <= size_sat;
            o_res_reg.row_pitch    <= p_pitch_reg;
            o_res_reg.row_count    <= p_rows_reg;
            o_res_reg.level_width  <= p_w_reg;
            o_res_reg.level_height <= p_h_reg;
            o_res_reg.level_depth  <= p_d_reg;
            o_res_reg.last_level   <= p_last_reg;
        end
    end

    assign res_valid = o_valid_reg;
    assign res       = o_res_reg;

endmodule

`default_nettype wire

// ----- dv/mip_chain_layout_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip chain layout core testbench
// Sends texture descriptions over the request stream and checks every level
// result against a level-by-level predictor of the chain layout. A short
// table of edge cases comes first, followed by random textures with bursty
// requests, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module mip_chain_layout_core_test;

    import mcl_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RANDOM_ITEMS   = 310;
    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 200;

    localparam logic [2:0] CLS_SPARE5 = 3'd5;
    localparam logic [2:0] CLS_SPARE6 = 3'd6;
    localparam logic [2:0] CLS_SPARE7 = 3'd7;

    typedef struct packed {
        logic [14:0] base_width;
        logic [14:0] base_height;
        logic [11:0] base_depth;
        logic [2:0]  format_class;
        logic [4:0]  level_count;
        logic        has_known;
        logic [30:0] known_size;
        logic [16:0] known_pitch;
        logic [14:0] known_rows;
    } texture_row_t;

    typedef res_t level_q_t[$];

    localparam int NUM_DIRECTED = 24;

    texture_row_t directed_rows [NUM_DIRECTED] = '{
        '{15'd0,     15'd0,     12'd0,    CLS_BLK8,   5'd1,  1'b1, 31'd8,          17'd8,      15'd1},
        '{15'd16384, 15'd16384, 12'd2048, CLS_BLK16,  5'd16, 1'b1, 31'd268435456,  17'd65536,  15'd4096},
        '{15'd16384, 15'd16384, 12'd2048, CLS_PIX4,   5'd16, 1'b1, 31'd1073741824, 17'd65536,  15'd16384},
        '{15'd32767, 15'd32767, 12'd4095, CLS_PIX4,   5'd16, 1'b1, 31'd2147483647, 17'd131068, 15'd32767},
        '{15'd32767, 15'd32767, 12'd4095, CLS_BLK16,  5'd31, 1'b1, 31'd1073741824, 17'd131071, 15'd8192},
        '{15'd32767, 15'd1,     12'd1,    CLS_PIX1,   5'd16, 1'b1, 31'd32767,      17'd32767,  15'd1},
        '{15'd1,     15'd32767, 12'd0,    CLS_PIX1,   5'd16, 1'b1, 31'd32767,      17'd1,      15'd32767},
        '{15'd100,   15'd50,    12'd7,    CLS_NONE,   5'd5,  1'b1, 31'd0,          17'd0,      15'd0},
        '{15'd64,    15'd64,    12'd64,   CLS_SPARE5, 5'd3,  1'b1, 31'd0,          17'd0,      15'd0},
        '{15'd33,    15'd17,    12'd3,    CLS_SPARE6, 5'd7,  1'b1, 31'd0,          17'd0,      15'd0},
        '{15'd8,     15'd8,     12'd1,    CLS_SPARE7, 5'd4,  1'b1, 31'd0,          17'd0,      15'd0},
        '{15'd256,   15'd256,   12'd1,    CLS_BLK8,   5'd0,  1'b0, 31'd0,          17'd0,      15'd0},
        '{15'd5,     15'd3,     12'd2,    CLS_BLK8,   5'd2,  1'b1, 31'd16,         17'd16,     15'd1},
        '{15'd5,     15'd3,     12'd2,    CLS_BLK16,  5'd2,  1'b1, 31'd32,         17'd32,     15'd1},
        '{15'd4,     15'd4,     12'd1,    CLS_PIX4,   5'd3,  1'b1, 31'd64,         17'd16,     15'd4},
        '{15'd7,     15'd9,     12'd5,    CLS_PIX1,   5'd4,  1'b1, 31'd63,         17'd7,      15'd9},
        '{15'd1024,  15'd512,   12'd0,    CLS_BLK8,   5'd17, 1'b0, 31'd0,          17'd0,      15'd0},
        '{15'd640,   15'd480,   12'd16,   CLS_PIX4,   5'd10, 1'b0, 31'd0,          17'd0,      15'd0},
        '{15'd1,     15'd1,     12'd1,    CLS_BLK16,  5'd1,  1'b1, 31'd16,         17'd16,     15'd1},
        '{15'd0,     15'd0,     12'd0,    CLS_PIX4,   5'd16, 1'b1, 31'd4,          17'd4,      15'd1},
        '{15'd12345, 15'd6789,  12'd1234, CLS_BLK8,   5'd12, 1'b0, 31'd0,          17'd0,      15'd0},
        '{15'd16384, 15'd1,     12'd2048, CLS_BLK16,  5'd15, 1'b0, 31'd0,          17'd0,      15'd0},
        '{15'd3,     15'd3,     12'd3,    CLS_PIX1,   5'd31, 1'b1, 31'd9,          17'd3,      15'd3},
        '{15'd0,     15'd200,   12'd0,    CLS_NONE,   5'd0,  1'b0, 31'd0,          17'd0,      15'd0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    res_t pending_levels[$];
    int   requests_sent;
    int   levels_checked;
    int   error_count;
    int   idle_cycles;
    int   burst_left;
    bit   hold_off_done;

    mip_chain_layout_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    function automatic level_q_t lay_out_chain(input texture_row_t row);
        level_q_t          levels;
        res_t              lv;
        longint unsigned   w;
        longint unsigned   h;
        longint unsigned   d;
        longint unsigned   bw;
        longint unsigned   bh;
        longint unsigned   unit;
        longint unsigned   sz;
        longint unsigned   pitch;
        longint unsigned   rows;
        longint unsigned   offset;
        int                n;
        n      = (row.level_count > MCL_MAX_LEVELS) ? MCL_MAX_LEVELS : int'(row.level_count);
        w      = (row.base_width == 0) ? 1 : row.base_width;
        h      = (row.base_height == 0) ? 1 : row.base_height;
        d      = row.base_depth;
        offset = 0;
        for (int i = 0; i < n; i++)
        begin
            bw = (w + 3) / 4;
            bh = (h + 3) / 4;
            case (row.format_class)
                CLS_BLK8, CLS_BLK16:
                begin
                    unit  = (row.format_class == CLS_BLK8) ? 8 : 16;
                    pitch = bw * unit;
                    rows  = bh;
                    sz    = bw * bh * unit;
                end
                CLS_PIX4, CLS_PIX1:
                begin
                    unit  = (row.format_class == CLS_PIX4) ? 4 : 1;
                    pitch = w * unit;
                    rows  = h;
                    sz    = w * h * unit;
                end
                default:
                begin
                    pitch = 0;
                    rows  = 0;
                    sz    = 0;
                end
            endcase
            if (sz > SIZE_MAX)
                sz = SIZE_MAX;
            lv.level_index  = i[3:0];
            lv.byte_offset  = offset[30:0];
            lv.byte_size    = sz[30:0];
            lv.row_pitch    = (pitch > PITCH_MAX) ? PITCH_MAX : pitch[16:0];
            lv.row_count    = rows[14:0];
            lv.level_width  = w[14:0];
            lv.level_height = h[14:0];
            lv.level_depth  = d[11:0];
            lv.last_level   = (i == n - 1);
            levels.insert(levels.size(), lv);
            offset = offset + sz;
            if (offset > SIZE_MAX)
                offset = SIZE_MAX;
            w = (w / 2 == 0) ? 1 : w / 2;
            h = (h / 2 == 0) ? 1 : h / 2;
            d = (d / 2 == 0) ? 1 : d / 2;
        end
        return levels;
    endfunction

    task automatic offer_request(input texture_row_t row);
        level_q_t chain;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, row.level_count, row.format_class, row.base_depth,
                     row.base_height, row.base_width};
        do
            @(posedge clk);
        while (!s_tready);
        chain = lay_out_chain(row);
        if (row.has_known && chain.size() > 0)
        begin
            chain[0].byte_size = row.known_size;
            chain[0].row_pitch = row.known_pitch;
            chain[0].row_count = row.known_rows;
        end
        foreach (chain[i])
            pending_levels.insert(pending_levels.size(), chain[i]);
        requests_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
    endtask

    function automatic logic [14:0] pick_extent();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 15'd0;
        else if (sel <= 2)
            return 15'($urandom_range(0, 32767));
        else if (sel == 3)
            return 15'd16384;
        else
            return 15'($urandom_range(1, 2048));
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            if (error_count < MAX_REPORTS)
                $display("%0t ns: level %s mismatch, expected %0d, got %0d",
                         $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_levels.size() == 0)
            begin
                $display("%0t ns: unexpected level result, expected none, got tdata %h",
                         $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_levels.pop_front();
                check_field("index",  want.level_index,  m_tdata[3:0]);
                check_field("offset", want.byte_offset,  m_tdata[34:4]);
                check_field("size",   want.byte_size,    m_tdata[65:35]);
                check_field("pitch",  want.row_pitch,    m_tdata[82:66]);
                check_field("rows",   want.row_count,    m_tdata[97:83]);
                check_field("width",  want.level_width,  m_tdata[112:98]);
                check_field("height", want.level_height, m_tdata[127:113]);
                check_field("depth",  want.level_depth,  m_tdata[139:128]);
                check_field("last",   want.last_level,   m_tlast);
                levels_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles, %0d level results outstanding",
                         $time, IDLE_LIMIT, pending_levels.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int mode;
        int mode_left;
        m_tready      = 1'b0;
        hold_off_done = 1'b0;
        mode          = 0;
        mode_left     = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_off_done && requests_sent >= 120)
            begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin
        texture_row_t row;
        int           sel;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        requests_sent  = 0;
        levels_checked = 0;
        error_count    = 0;
        idle_cycles    = 0;
        burst_left     = 4;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            offer_request(directed_rows[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            row              = '0;
            row.base_width   = pick_extent();
            row.base_height  = pick_extent();
            row.base_depth   = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 4095))
                                                           : 12'($urandom_range(0, 64));
            row.format_class = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3))
                                                          : 3'($urandom_range(4, 7));
            sel              = $urandom_range(0, 7);
            row.level_count  = (sel == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(1, 16));
            offer_request(row);
        end
        if (s_tvalid)
            s_tvalid <= 1'b0;

        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d texture requests (%0d from the edge-case table)",
                 requests_sent, NUM_DIRECTED);
        $display("and %0d level results, with all format classes, saturating sizes and %s",
                 levels_checked, "pitches, and a long output hold-off.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
